@@ hdl/mi3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types, widths and index tables for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned NELEM  = 9;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 64;   // 2x2 minor product
  localparam int unsigned COF_W  = 65;   // signed cofactor
  localparam int unsigned CMAG_W = 64;   // cofactor magnitude
  localparam int unsigned PART_W = 65;   // elem x cofactor half
  localparam int unsigned DET_W  = 98;   // signed determinant
  localparam int unsigned DMAG_W = 97;   // determinant magnitude
  localparam int unsigned QBITS  = 33;   // quotient bits below overflow
  localparam int unsigned STAT_W = 2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_SING = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // Minor operands per inverse element: a*b - c*d
  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // Per-stage divider control
  typedef struct packed {
    logic [NELEM-1:0]  neg;
    logic [NELEM-1:0]  ovf;
    logic              sing;
    logic [DMAG_W-1:0] dmag;
  } dctl_t;

endpackage
`default_nettype wire

@@ hdl/mi3_cofactor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: 2x2 minor products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      adv,
  input  wire                      vld_in,
  input  mi3_pkg::elem_t           elem [mi3_pkg::NELEM],
  output logic                     vld_out,
  output mi3_pkg::elem_t           elem_out [mi3_pkg::NELEM],
  output mi3_pkg::cof_t            cof_out [mi3_pkg::NELEM]
);

  function automatic logic signed [mi3_pkg::PROD_W-1:0] mul32s(
    input mi3_pkg::elem_t a, input mi3_pkg::elem_t b);
    logic signed [mi3_pkg::PROD_W-1:0] ax;
    logic signed [mi3_pkg::PROD_W-1:0] bx;
    ax = a;
    bx = b;
    return ax * bx;
  endfunction

  logic signed [mi3_pkg::PROD_W-1:0] pab_r [mi3_pkg::NELEM];
  logic signed [mi3_pkg::PROD_W-1:0] pcd_r [mi3_pkg::NELEM];
  mi3_pkg::elem_t                    e1_r  [mi3_pkg::NELEM];
  mi3_pkg::elem_t                    e2_r  [mi3_pkg::NELEM];
  mi3_pkg::cof_t                     cof_r [mi3_pkg::NELEM];
  logic                              v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
        pab_r[k] <= mul32s(elem[mi3_pkg::COF_IDX[k][0]], elem[mi3_pkg::COF_IDX[k][1]]);
        pcd_r[k] <= mul32s(elem[mi3_pkg::COF_IDX[k][2]], elem[mi3_pkg::COF_IDX[k][3]]);
        e1_r[k]  <= elem[k];
        cof_r[k] <= mi3_pkg::COF_W'(pab_r[k]) - mi3_pkg::COF_W'(pcd_r[k]);
        e2_r[k]  <= e1_r[k];
      end
    end
  end

  assign vld_out  = v2_r;
  assign elem_out = e2_r;
  assign cof_out  = cof_r;

endmodule
`default_nettype wire

@@ hdl/mi3_det.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det
// Three stages: determinant as first row dotted with adjugate column 0.
// Cofactors ride along to stay aligned.
// ----------------------------------------------------------------------------
module mi3_det (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      adv,
  input  wire                      vld_in,
  input  mi3_pkg::elem_t           elem [mi3_pkg::NELEM],
  input  mi3_pkg::cof_t            cof  [mi3_pkg::NELEM],
  output logic                     vld_out,
  output mi3_pkg::cof_t            cof_out [mi3_pkg::NELEM],
  output mi3_pkg::det_t            det_out
);

  // adjugate entries (0,0) (1,0) (2,0) pair with elem 0, 1, 2
  localparam int unsigned ADJ_COL [3] = '{0, 3, 6};

  logic signed [mi3_pkg::PART_W-1:0] mhi_r [3];
  logic signed [mi3_pkg::PART_W-1:0] mlo_r [3];
  mi3_pkg::det_t                     t_r   [3];
  mi3_pkg::det_t                     det_r;
  mi3_pkg::cof_t                     c1_r [mi3_pkg::NELEM];
  mi3_pkg::cof_t                     c2_r [mi3_pkg::NELEM];
  mi3_pkg::cof_t                     c3_r [mi3_pkg::NELEM];
  logic                              v1_r, v2_r, v3_r;

  logic signed [mi3_pkg::PART_W-1:0] mhi_nxt [3];
  logic signed [mi3_pkg::PART_W-1:0] mlo_nxt [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [mi3_pkg::PART_W-1:0] ex, hx, lx;
      ex = elem[j];
      hx = $signed(cof[ADJ_COL[j]][mi3_pkg::COF_W-1:32]);
      lx = $signed({33'b0, cof[ADJ_COL[j]][31:0]});
      mhi_nxt[j] = ex * hx;
      mlo_nxt[j] = ex * lx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        mhi_r[j] <= mhi_nxt[j];
        mlo_r[j] <= mlo_nxt[j];
        t_r[j]   <= (mi3_pkg::DET_W'(mhi_r[j]) <<< 32) + mi3_pkg::DET_W'(mlo_r[j]);
      end
      det_r <= t_r[0] + t_r[1] + t_r[2];
      c1_r  <= cof;
      c2_r  <= c1_r;
      c3_r  <= c2_r;
    end
  end

  assign vld_out = v3_r;
  assign cof_out = c3_r;
  assign det_out = det_r;

endmodule
`default_nettype wire

@@ hdl/mi3_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_divider
// Nine-lane restoring divider, one quotient bit per stage, shared divisor.
// Sign/magnitude prep, overflow screen, 33 bit stages, rounding, saturation.
// ----------------------------------------------------------------------------
module mi3_divider (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      adv,
  input  wire                                      vld_in,
  input  mi3_pkg::cof_t                            cof [mi3_pkg::NELEM],
  input  mi3_pkg::det_t                            det,
  output logic                                     vld_out,
  output logic [mi3_pkg::NELEM*mi3_pkg::ELEM_W-1:0] res_out,
  output mi3_pkg::status_t                         status_out
);

  localparam int unsigned NST = mi3_pkg::QBITS + 3;   // prep, screen, bits, round

  logic [NST-1:0] v_r;

  // prep stage
  mi3_pkg::dctl_t             ctl0_r;
  logic [mi3_pkg::CMAG_W-1:0] cmag_r [mi3_pkg::NELEM];

  // bit stages: index 0 is the screen output
  mi3_pkg::dctl_t             ctl_r [mi3_pkg::QBITS+1];
  logic [mi3_pkg::DMAG_W-1:0] rem_r [mi3_pkg::QBITS+1][mi3_pkg::NELEM];
  logic [mi3_pkg::QBITS-1:0]  q_r   [mi3_pkg::QBITS+1][mi3_pkg::NELEM];
  logic [mi3_pkg::NELEM-1:0]  lsb_r;

  // round stage
  mi3_pkg::dctl_t             ctlq_r;
  logic [mi3_pkg::QBITS:0]    qr_r [mi3_pkg::NELEM];
  logic [mi3_pkg::DMAG_W-1:0] ctlq_dmag_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], vld_in};
    end
  end

  // prep: magnitudes and signs
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl0_r.sing <= (det == '0);
      ctl0_r.dmag <= det[mi3_pkg::DET_W-1] ? mi3_pkg::DMAG_W'(-det)
                                           : mi3_pkg::DMAG_W'(det);
      ctl0_r.ovf  <= '0;
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
        ctl0_r.neg[k] <= cof[k][mi3_pkg::COF_W-1] ^ det[mi3_pkg::DET_W-1];
        cmag_r[k]     <= cof[k][mi3_pkg::COF_W-1] ? mi3_pkg::CMAG_W'(-cof[k])
                                                  : mi3_pkg::CMAG_W'(cof[k]);
      end
    end
  end

  // screen: quotient of 2^33 or more saturates regardless
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0].sing <= ctl0_r.sing;
      ctl_r[0].dmag <= ctl0_r.dmag;
      ctl_r[0].neg  <= ctl0_r.neg;
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
        ctl_r[0].ovf[k] <= mi3_pkg::DMAG_W'(cmag_r[k] >> 1) >= ctl0_r.dmag;
        rem_r[0][k]     <= mi3_pkg::DMAG_W'(cmag_r[k] >> 1);
        q_r[0][k]       <= '0;
        lsb_r[k]        <= cmag_r[k][0];
      end
    end
  end

  for (genvar s = 0; s < mi3_pkg::QBITS; s++) begin : g_bit
    logic [mi3_pkg::DMAG_W-1:0] rem_nxt [mi3_pkg::NELEM];
    logic [mi3_pkg::QBITS-1:0]  q_nxt   [mi3_pkg::NELEM];

    always_comb begin
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
        logic [mi3_pkg::DMAG_W:0] shin, trial;
        shin  = {rem_r[s][k], (s == 0) ? lsb_r[k] : 1'b0};
        trial = shin - {1'b0, ctl_r[s].dmag};
        rem_nxt[k] = trial[mi3_pkg::DMAG_W] ? shin[mi3_pkg::DMAG_W-1:0]
                                            : trial[mi3_pkg::DMAG_W-1:0];
        q_nxt[k]   = {q_r[s][k][mi3_pkg::QBITS-2:0], ~trial[mi3_pkg::DMAG_W]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[s+1] <= ctl_r[s];
        rem_r[s+1] <= rem_nxt;
        q_r[s+1]   <= q_nxt;
      end
    end
  end

  assign ctlq_dmag_w = ctl_r[mi3_pkg::QBITS].dmag;

  // round half away from zero on magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      ctlq_r <= ctl_r[mi3_pkg::QBITS];
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
        qr_r[k] <= {1'b0, q_r[mi3_pkg::QBITS][k]}
                 + (mi3_pkg::QBITS+1)'({rem_r[mi3_pkg::QBITS][k], 1'b0}
                                        >= {1'b0, ctlq_dmag_w});
      end
    end
  end

  // saturate, apply sign
  always_comb begin
    logic                       any_sat;
    logic [mi3_pkg::QBITS:0]    lim;
    logic                       sat;
    logic [mi3_pkg::ELEM_W-1:0] mag;
    any_sat = 1'b0;
    res_out = '0;
    for (int k = 0; k < mi3_pkg::NELEM; k++) begin
      lim = ctlq_r.neg[k] ? (mi3_pkg::QBITS+1)'(34'h0_8000_0000)
                          : (mi3_pkg::QBITS+1)'(34'h0_7FFF_FFFF);
      sat = ctlq_r.ovf[k] | (qr_r[k] > lim);
      mag = sat ? lim[mi3_pkg::ELEM_W-1:0] : qr_r[k][mi3_pkg::ELEM_W-1:0];
      any_sat = any_sat | sat;
      if (!ctlq_r.sing) begin
        res_out[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] =
          ctlq_r.neg[k] ? mi3_pkg::ELEM_W'(0) - mag : mag;
      end
    end
    if (ctlq_r.sing)  status_out = mi3_pkg::ST_SING;
    else if (any_sat) status_out = mi3_pkg::ST_SAT;
    else              status_out = mi3_pkg::ST_OK;
  end

  assign vld_out = v_r[NST-1];

endmodule
`default_nettype wire

@@ hdl/matrix3_inverse.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 Q16.16 matrix inverse via adjugate / determinant, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  data                      side
//  in_      in   elem_00..elem_22 (tdata)  -
//  out_     out  inv_00..inv_22 (tdata)    status (tuser)
//
//  One matrix per cycle while out_ is not held (see stall note below).
//  Depth is set by the divider: one quotient bit per stage, 33 stages.
//  rst_n (sync, active low) clears all valid bits; data regs are not reset.
//  A held output (out_tvalid & !out_tready) freezes the whole pipe and
//  drops in_tready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module matrix3_inverse (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [287:0] in_tdata,   // elem_00, elem_01, elem_02, elem_10, elem_11,
                                   // elem_12, elem_20, elem_21, elem_22 (32b each)
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [287:0] out_tdata,  // inv_00, inv_01, inv_02, inv_10, inv_11,
                                   // inv_12, inv_20, inv_21, inv_22 (32b each)
  output logic [7:0]   out_tuser   // status [1:0], zero fill [7:2]
);

  logic adv;

  mi3_pkg::elem_t   elem [mi3_pkg::NELEM];
  logic             cof_vld;
  mi3_pkg::elem_t   cof_elem [mi3_pkg::NELEM];
  mi3_pkg::cof_t    cof [mi3_pkg::NELEM];
  logic             det_vld;
  mi3_pkg::cof_t    det_cof [mi3_pkg::NELEM];
  mi3_pkg::det_t    det;
  logic             div_vld;
  logic [287:0]     div_res;
  mi3_pkg::status_t div_stat;

  logic             out_valid_r;
  logic [287:0]     out_data_r;
  mi3_pkg::status_t out_stat_r;

  // pipe moves whenever the output register is free or being drained
  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = adv;

  for (genvar k = 0; k < mi3_pkg::NELEM; k++) begin : g_unpack
    assign elem[k] = in_tdata[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
  end

  mi3_cofactor u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .vld_in   (in_tvalid),
    .elem     (elem),
    .vld_out  (cof_vld),
    .elem_out (cof_elem),
    .cof_out  (cof)
  );

  mi3_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_in  (cof_vld),
    .elem    (cof_elem),
    .cof     (cof),
    .vld_out (det_vld),
    .cof_out (det_cof),
    .det_out (det)
  );

  mi3_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .vld_in     (det_vld),
    .cof        (det_cof),
    .det        (det),
    .vld_out    (div_vld),
    .res_out    (div_res),
    .status_out (div_stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= div_res;
      out_stat_r <= div_stat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {6'b0, out_stat_r};

`ifndef SYNTHESIS
  // singular result carries all-zero elements
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r == mi3_pkg::ST_SING |-> out_data_r == '0)
    else $error("singular result with nonzero data");

  // a stall freezes the determinant stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(det_vld) && $stable(det))
    else $error("pipeline moved during stall");

  // status only takes a defined code
  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_stat_r == mi3_pkg::ST_OK || out_stat_r == mi3_pkg::ST_SING
                    || out_stat_r == mi3_pkg::ST_SAT)
    else $error("bad status code");
`endif

endmodule
`default_nettype wire

@@ tb/sv/matrix3_inverse_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_chk
// Watches both streams of the matrix inverse, predicts each inverse with exact
// wide arithmetic and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module matrix3_inverse_chk (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [287:0] in_tdata,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [287:0] out_tdata,
  input  wire  [7:0]   out_tuser,
  output int           errors,
  output int           pending,
  output int           n_ok,
  output int           n_sing,
  output int           n_sat
);

  typedef struct {
    logic [287:0] inv;
    logic [7:0]   stat;
  } inverse_t;

  inverse_t inv_q[$];

  // Exact adjugate / determinant, rounded half away from zero, saturated.
  function automatic inverse_t invert(input logic [287:0] m);
    logic signed [127:0] e[9];
    logic signed [127:0] det, cof, val;
    logic [127:0] dmag, cmag, q, lim;
    logic neg, sat;
    inverse_t r;
    int k;
    for (k = 0; k < 9; k++) e[k] = {{96{m[32*k+31]}}, m[32*k +: 32]};
    det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
        - e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[0]*e[5]*e[7];
    r.inv = '0;
    if (det == 0) begin
      r.stat = 8'(mi3_pkg::ST_SING);
      return r;
    end
    dmag = det[127] ? -det : det;
    sat  = 1'b0;
    for (k = 0; k < 9; k++) begin
      cof  = e[mi3_pkg::COF_IDX[k][0]] * e[mi3_pkg::COF_IDX[k][1]]
           - e[mi3_pkg::COF_IDX[k][2]] * e[mi3_pkg::COF_IDX[k][3]];
      cmag = cof[127] ? -cof : cof;
      q    = ((cmag << 33) + dmag) / (dmag << 1);
      neg  = cof[127] != det[127];
      lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
        q   = lim;
        sat = 1'b1;
      end
      val = neg ? -q : q;
      r.inv[32*k +: 32] = val[31:0];
    end
    r.stat = sat ? 8'(mi3_pkg::ST_SAT) : 8'(mi3_pkg::ST_OK);
    return r;
  endfunction

  always @(posedge clk) begin
    inverse_t x;
    int k;
    logic bad;
    if (!rst_n) begin
      errors <= 0;
      n_ok   <= 0;
      n_sing <= 0;
      n_sat  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        x = invert(in_tdata);
        inv_q.push_back(x);
        case (x.stat[1:0])
          mi3_pkg::ST_OK:   n_ok   <= n_ok + 1;
          mi3_pkg::ST_SING: n_sing <= n_sing + 1;
          default:          n_sat  <= n_sat + 1;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (inv_q.size() == 0) begin
          if (errors < 10) $display("ERROR: result transfer with nothing outstanding");
          errors <= errors + 1;
        end else begin
          x   = inv_q.pop_front();
          bad = 1'b0;
          for (k = 0; k < 9; k++) begin
            if (out_tdata[32*k +: 32] !== x.inv[32*k +: 32]) begin
              bad = 1'b1;
              if (errors < 10)
                $display("ERROR: inv_%0d%0d exp %h got %h", k / 3, k % 3,
                         x.inv[32*k +: 32], out_tdata[32*k +: 32]);
            end
          end
          if (out_tuser !== x.stat) begin
            bad = 1'b1;
            if (errors < 10) $display("ERROR: status exp %h got %h", x.stat, out_tuser);
          end
          if (bad) errors <= errors + 1;
        end
      end
    end
    pending <= inv_q.size();
  end

endmodule

@@ tb/sv/matrix3_inverse_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_tb
// Streams directed and random 3x3 Q16.16 matrices with random gaps and
// back-pressure; the checker predicts and compares every inverse.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;

  localparam int N_RAND   = 1700;
  localparam int WDOG_MAX = 5000;   // idle cycles before giving up
  localparam int DRAIN    = 60;     // pipe is 42 deep

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic [7:0]   out_tuser;
  int           errors, pending, n_ok, n_sing, n_sat;
  int           wdog = 0;
  bit           calm = 1'b0;        // both sides run without gaps while set

  always #6 clk = ~clk;

  matrix3_inverse dut (.*);

  matrix3_inverse_chk chk (.*);

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("matrix3_inverse_tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] q16(input int v);
    return 32'(v) << 16;
  endfunction

  // Element flavors: full range, moderate Q16.16, tiny, and extremes.
  function automatic logic [31:0] pick_elem(input int kind);
    case (kind)
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2:       return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [287:0] rand_matrix();
    logic [287:0] m;
    int kind, k, r;
    kind = $urandom_range(0, 9);
    for (k = 0; k < 9; k++)
      m[32*k +: 32] = pick_elem(kind < 2 ? 0 : kind < 6 ? 1 : kind < 8 ? 2 :
                                $urandom_range(0, 3));
    // A share of singular matrices: one row repeats or is zero.
    if ($urandom_range(0, 7) == 0) begin
      r = $urandom_range(0, 2);
      m[96*((r + 1) % 3) +: 96] = $urandom_range(0, 1) ? m[96*r +: 96] : 96'd0;
    end
    return m;
  endfunction

  task automatic send(input logic [287:0] m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Result side back-pressure.
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    logic [287:0] m;
    int i, k;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: identity, zero, scaled diagonals, extremes, rank-one.
    m = '0;
    for (k = 0; k < 9; k += 4) m[32*k +: 32] = q16(1);
    send(m);
    send('0);
    for (k = 0; k < 9; k += 4) m[32*k +: 32] = q16(-1);
    send(m);
    for (k = 0; k < 9; k += 4) m[32*k +: 32] = 32'd1;          // tiny: saturates
    send(m);
    for (k = 0; k < 9; k += 4) m[32*k +: 32] = 32'hFFFF_FFFF;
    send(m);
    for (k = 0; k < 9; k += 4) m[32*k +: 32] = 32'h7FFF_FFFF;
    send(m);
    for (k = 0; k < 9; k += 4) m[32*k +: 32] = 32'h8000_0000;
    send(m);
    send({9{32'h7FFF_FFFF}});
    send({9{32'h8000_0000}});
    send({9{32'hFFFF_FFFF}});
    m = '0;                                                     // rounding of inexact quotients
    m[0 +: 32] = q16(2); m[128 +: 32] = q16(3); m[256 +: 32] = q16(-7);
    send(m);
    m = {q16(9), q16(8), q16(7), q16(6), q16(5), q16(4), q16(3), q16(2), q16(1)};
    send(m);                                                    // singular
    m[256 +: 32] = q16(10);
    send(m);
    m = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
         32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000};
    send(m);
    m = {32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001,
         32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001};
    send(m);

    for (i = 0; i < N_RAND; i++) begin
      if (i % 200 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == N_RAND / 2) begin
        in_tvalid <= 1'b0;
        wait (pending == 0);                                    // full drain mid-run
        @(negedge clk);
      end
      send(rand_matrix());
    end
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    $display("Inverted %0d matrices: %0d regular, %0d singular, %0d saturated,",
             n_ok + n_sing + n_sat, n_ok, n_sing, n_sat);
    $display("with random gaps and back-pressure on both streams.");
    if (errors == 0 && pending == 0) begin
      $display("matrix3_inverse_tb passed");
    end else begin
      $display("matrix3_inverse_tb failed");
    end
    $finish;
  end

endmodule
